// File: hw/rtl/dcmc_pkg.sv
// ----------------------------------------------------------------------------
// dcmc_pkg: shared types for the divisor closure min-cut block
// Queue entry, RAM word layouts, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package dcmc_pkg;

   localparam int VALUE_W = 16;
   localparam int TOTAL_W = 24;
   localparam int RESID_W = 17;

   localparam logic [RESID_W-1:0] CAP_MAX = '1;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               store;
      logic               last;
      logic               ovf;
   } entry_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [RESID_W-1:0] resid;
   } item_word_type;

   typedef struct packed {
      logic               link;
      logic [RESID_W-1:0] amount;
   } flow_word_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_CLEAR,
      ST_BFS_INIT,
      ST_POP_RD,
      ST_POP_GET,
      ST_SINK_RD,
      ST_SINK_EVAL,
      ST_SCAN,
      ST_SCAN_EVAL,
      ST_WALK_INIT,
      ST_PRED_RD,
      ST_PRED_GET,
      ST_EDGE_EVAL,
      ST_SUM_RD,
      ST_SUM_EVAL,
      ST_RESULT
   } back_state_type;

endpackage

`default_nettype wire

// File: hw/rtl/divisor_closure_min_cut.sv
// Items load at one per cycle while the queue has room; the tlast entry passes
// through the two-entry queue to the sequencer, which clears the n x n flow
// table, then runs one breadth-first search per augmenting path and a two-pass
// walk along each path, a final search and a sum over the source-side items;
// the result goes to a result register. The sequencer takes one batch at a time;
// the two-entry queue holds input meanwhile. Synchronous reset empties all control.
// ----------------------------------------------------------------------------
// divisor_closure_min_cut: top level
// Input stage, two-entry queue and flow sequencer with a result register.
// ----------------------------------------------------------------------------
`default_nettype none

module divisor_closure_min_cut #(
   parameter int MAX_ITEMS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] item_value
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata    // [23:0] total, [24] overflow
);

   import dcmc_pkg::*;

   logic        fq_valid, fq_ready;
   entry_type   fq_data;
   logic        qb_valid, qb_ready;
   entry_type   qb_data;
   logic [23:0] rsp_total;
   logic        rsp_ovf;

   dcmc_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_valid    (fq_valid),
      .q_ready    (fq_ready),
      .q_data     (fq_data)
   );

   dcmc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   dcmc_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (qb_valid),
      .q_ready    (qb_ready),
      .q_data     (qb_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_total  (rsp_total),
      .rsp_ovf    (rsp_ovf)
   );

   assign rsp_tdata = {7'b0, rsp_ovf, rsp_total};

endmodule

`default_nettype wire

// File: hw/rtl/dcmc_ram.sv
// ----------------------------------------------------------------------------
// dcmc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dcmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/dcmc_front.sv
// ----------------------------------------------------------------------------
// dcmc_front: input stage
// Counts items of a batch, drops items past capacity and tags each queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module dcmc_front #(
   parameter int MAX_ITEMS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [15:0]           req_tdata,
   input  wire logic                  req_tlast,
   output logic                       q_valid,
   input  wire logic                  q_ready,
   output dcmc_pkg::entry_type        q_data
);

   import dcmc_pkg::*;

   localparam int CW = $clog2(MAX_ITEMS + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          excess_ff, excess_in;
   logic          store;
   logic          accept;

   assign store      = count_ff < CW'(MAX_ITEMS);
   assign req_tready = q_ready;
   assign accept     = req_tvalid && req_tready;
   assign q_valid    = req_tvalid && (store || req_tlast);

   always_comb begin
      q_data.value = req_tdata;
      q_data.store = store;
      q_data.last  = req_tlast;
      q_data.ovf   = excess_ff || !store;
   end

   always_comb begin
      count_in  = count_ff;
      excess_in = excess_ff;
      if (accept) begin
         if (req_tlast) begin
            count_in  = '0;
            excess_in = 1'b0;
         end else if (store) begin
            count_in = count_ff + CW'(1);
         end else begin
            excess_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         excess_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         excess_ff <= excess_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/dcmc_fifo.sv
// ----------------------------------------------------------------------------
// dcmc_fifo: two-entry queue between front and back
// Lets the input side keep taking items while the sequencer is busy.
// ----------------------------------------------------------------------------
`default_nettype none

module dcmc_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   output logic                      push_ready,
   input  wire dcmc_pkg::entry_type  push_data,
   output logic                      pop_valid,
   input  wire logic                 pop_ready,
   output dcmc_pkg::entry_type       pop_data
);

   import dcmc_pkg::*;

   entry_type  entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign push_ready = cnt_ff != 2'd2;
   assign pop_valid  = cnt_ff != 2'd0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/dcmc_back.sv
// ----------------------------------------------------------------------------
// dcmc_back: flow sequencer
// Stores a batch, runs breadth-first augmenting paths over the residual
// network, finds the source side of the cut and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dcmc_back #(
   parameter int MAX_ITEMS = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   output logic                      q_ready,
   input  wire dcmc_pkg::entry_type  q_data,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [23:0]               rsp_total,
   output logic                      rsp_ovf
);

   import dcmc_pkg::*;

   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int NW = $clog2(MAX_ITEMS + 2);
   localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int FW = 2 * IW;
   localparam int ND = MAX_ITEMS + 2;

   back_state_type       state_ff, state_in;
   logic [CW-1:0]        n_ff, n_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic                 ovf_ff, ovf_in;
   logic                 final_ff, final_in;
   logic                 phase_ff, phase_in;
   logic [IW-1:0]        ci_ff, ci_in, cj_ff, cj_in;
   logic [NW:0]          mult_ff, mult_in;
   logic [ND-1:0]        vis_ff, vis_in;
   logic [MAX_ITEMS:0]   neg_ff, neg_in, pos_ff, pos_in;
   logic [NW-1:0]        head_ff, head_in, tail_ff, tail_in;
   logic [NW-1:0]        cur_ff, cur_in, nx_ff, nx_in;
   logic [NW-1:0]        node_ff, node_in, prev_ff, prev_in;
   logic [RESID_W-1:0]   b_ff, b_in;
   logic [IW-1:0]        item_addr_ff, item_addr_in;
   logic [FW-1:0]        flow_addr_ff, flow_addr_in;
   logic                 out_valid_ff, out_valid_in;
   logic [TOTAL_W-1:0]   out_total_ff, out_total_in;
   logic                 out_ovf_ff, out_ovf_in;

   logic                 item_we;
   logic [IW-1:0]        item_wa, item_ra;
   item_word_type        item_wd, item_rd;
   logic                 flow_we;
   logic [FW-1:0]        flow_wa, flow_ra;
   flow_word_type        flow_wd, flow_rd;
   logic                 pred_we;
   logic [NW-1:0]        pred_wa, pred_wd, pred_ra, pred_rd;
   logic                 que_we;
   logic [NW-1:0]        que_wa, que_wd, que_ra, que_rd;

   logic [NW-1:0]        sink;
   logic [NW-1:0]        n_node;
   logic [NW-1:0]        load_node;
   logic [RESID_W-1:0]   load_resid;
   logic [NW-1:0]        i_node, j_node;
   logic                 hit;
   logic [IW-1:0]        last_idx;
   logic                 cur_neg;
   logic                 cand;
   logic                 scan_ok;
   logic                 walk_item, walk_fwd;
   logic [RESID_W-1:0]   walk_cap;
   logic [IW-1:0]        pg_item_addr;
   logic [FW-1:0]        pg_flow_addr;

   assign n_node     = NW'(n_ff);
   assign sink       = n_node + NW'(1);
   assign load_node  = n_node + NW'(1);
   assign load_resid = q_data.value[VALUE_W-1]
                       ? (RESID_W'(0) - {1'b1, q_data.value})
                       : {1'b0, q_data.value};
   assign i_node     = NW'(ci_ff) + NW'(1);
   assign j_node     = NW'(cj_ff) + NW'(1);
   assign hit        = {1'b0, j_node} == mult_ff;
   assign last_idx   = IW'(n_node - NW'(1));
   assign cur_neg    = (cur_ff != '0) && neg_ff[cur_ff];
   assign cand       = !vis_ff[nx_ff] &&
                       ((cur_ff == '0) ? neg_ff[nx_ff] :
                        (cur_neg ? pos_ff[nx_ff] : neg_ff[nx_ff]));
   assign scan_ok    = (cur_ff == '0) ? (item_rd.resid != '0) :
                       (cur_neg ? flow_rd.link : (flow_rd.amount != '0));
   assign walk_item  = (node_ff == sink) || (prev_ff == '0);
   assign walk_fwd   = !walk_item && neg_ff[prev_ff];
   assign walk_cap   = walk_item ? item_rd.resid : flow_rd.amount;
   assign pg_item_addr = (node_ff == sink) ? IW'(pred_rd - NW'(1)) : IW'(node_ff - NW'(1));
   assign pg_flow_addr = ((pred_rd != '0) && neg_ff[pred_rd])
                         ? {IW'(pred_rd - NW'(1)), IW'(node_ff - NW'(1))}
                         : {IW'(node_ff - NW'(1)), IW'(pred_rd - NW'(1))};

   dcmc_ram #(.WIDTH(VALUE_W + RESID_W), .DEPTH(MAX_ITEMS)) u_item_ram (
      .clock   (clock),
      .wr_en   (item_we),
      .wr_addr (item_wa),
      .wr_data (item_wd),
      .rd_addr (item_ra),
      .rd_data (item_rd)
   );

   dcmc_ram #(.WIDTH(1 + RESID_W), .DEPTH(2 ** FW)) u_flow_ram (
      .clock   (clock),
      .wr_en   (flow_we),
      .wr_addr (flow_wa),
      .wr_data (flow_wd),
      .rd_addr (flow_ra),
      .rd_data (flow_rd)
   );

   dcmc_ram #(.WIDTH(NW), .DEPTH(ND)) u_pred_ram (
      .clock   (clock),
      .wr_en   (pred_we),
      .wr_addr (pred_wa),
      .wr_data (pred_wd),
      .rd_addr (pred_ra),
      .rd_data (pred_rd)
   );

   dcmc_ram #(.WIDTH(NW), .DEPTH(ND)) u_queue_ram (
      .clock   (clock),
      .wr_en   (que_we),
      .wr_addr (que_wa),
      .wr_data (que_wd),
      .rd_addr (que_ra),
      .rd_data (que_rd)
   );

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      final_in     = final_ff;
      phase_in     = phase_ff;
      ci_in        = ci_ff;
      cj_in        = cj_ff;
      mult_in      = mult_ff;
      vis_in       = vis_ff;
      neg_in       = neg_ff;
      pos_in       = pos_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cur_in       = cur_ff;
      nx_in        = nx_ff;
      node_in      = node_ff;
      prev_in      = prev_ff;
      b_in         = b_ff;
      item_addr_in = item_addr_ff;
      flow_addr_in = flow_addr_ff;
      out_valid_in = out_valid_ff;
      out_total_in = out_total_ff;
      out_ovf_in   = out_ovf_ff;

      q_ready = 1'b0;
      item_we = 1'b0;
      item_wa = item_addr_ff;
      item_wd = item_rd;
      item_ra = item_addr_ff;
      flow_we = 1'b0;
      flow_wa = flow_addr_ff;
      flow_wd = flow_rd;
      flow_ra = flow_addr_ff;
      pred_we = 1'b0;
      pred_wa = nx_ff;
      pred_wd = cur_ff;
      pred_ra = node_ff;
      que_we  = 1'b0;
      que_wa  = tail_ff;
      que_wd  = nx_ff;
      que_ra  = head_ff;

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_LOAD: begin
            q_ready = 1'b1;
            if (q_valid) begin
               if (q_data.store) begin
                  item_we             = 1'b1;
                  item_wa             = IW'(n_ff);
                  item_wd.value       = q_data.value;
                  item_wd.resid       = load_resid;
                  neg_in[load_node]   = q_data.value[VALUE_W-1];
                  pos_in[load_node]   = !q_data.value[VALUE_W-1] && (q_data.value != '0);
                  n_in                = n_ff + CW'(1);
                  total_in            = total_ff +
                                        {{(TOTAL_W-VALUE_W){q_data.value[VALUE_W-1]}},
                                         q_data.value};
               end
               if (q_data.last) begin
                  ovf_in  = q_data.ovf;
                  ci_in   = '0;
                  cj_in   = '0;
                  mult_in = (NW+1)'(2);
                  if (n_in == '0) begin
                     state_in = ST_RESULT;
                  end else begin
                     state_in = ST_CLEAR;
                  end
               end
            end
         end
         ST_CLEAR: begin
            flow_we        = 1'b1;
            flow_wa        = {ci_ff, cj_ff};
            flow_wd.link   = hit && neg_ff[i_node] && pos_ff[j_node];
            flow_wd.amount = '0;
            if (cj_ff == last_idx) begin
               if (ci_ff == last_idx) begin
                  final_in = 1'b0;
                  state_in = ST_BFS_INIT;
               end else begin
                  ci_in   = ci_ff + IW'(1);
                  cj_in   = '0;
                  mult_in = ((NW+1)'(ci_ff) + (NW+1)'(2)) << 1;
               end
            end else begin
               cj_in = cj_ff + IW'(1);
               if (hit) begin
                  mult_in = mult_ff + (NW+1)'(i_node);
               end
            end
         end
         ST_BFS_INIT: begin
            vis_in    = '0;
            vis_in[0] = 1'b1;
            que_we    = 1'b1;
            que_wa    = '0;
            que_wd    = '0;
            head_in   = '0;
            tail_in   = NW'(1);
            state_in  = ST_POP_RD;
         end
         ST_POP_RD: begin
            if (head_ff == tail_ff) begin
               if (final_ff) begin
                  nx_in    = NW'(1);
                  state_in = ST_SUM_RD;
               end else begin
                  final_in = 1'b1;
                  state_in = ST_BFS_INIT;
               end
            end else begin
               state_in = ST_POP_GET;
            end
         end
         ST_POP_GET: begin
            cur_in  = que_rd;
            head_in = head_ff + NW'(1);
            nx_in   = NW'(1);
            if (!final_ff && (que_rd != '0) && pos_ff[que_rd]) begin
               state_in = ST_SINK_RD;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SINK_RD: begin
            item_ra  = IW'(cur_ff - NW'(1));
            state_in = ST_SINK_EVAL;
         end
         ST_SINK_EVAL: begin
            if (item_rd.resid != '0) begin
               pred_we  = 1'b1;
               pred_wa  = sink;
               pred_wd  = cur_ff;
               state_in = ST_WALK_INIT;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            item_ra = IW'(nx_ff - NW'(1));
            flow_ra = cur_neg ? {IW'(cur_ff - NW'(1)), IW'(nx_ff - NW'(1))}
                              : {IW'(nx_ff - NW'(1)), IW'(cur_ff - NW'(1))};
            if (nx_ff > n_node) begin
               state_in = ST_POP_RD;
            end else if (cand) begin
               state_in = ST_SCAN_EVAL;
            end else begin
               nx_in = nx_ff + NW'(1);
            end
         end
         ST_SCAN_EVAL: begin
            if (scan_ok) begin
               vis_in[nx_ff] = 1'b1;
               pred_we       = 1'b1;
               que_we        = 1'b1;
               tail_in       = tail_ff + NW'(1);
            end
            nx_in    = nx_ff + NW'(1);
            state_in = ST_SCAN;
         end
         ST_WALK_INIT: begin
            node_in  = sink;
            b_in     = CAP_MAX;
            phase_in = 1'b0;
            state_in = ST_PRED_RD;
         end
         ST_PRED_RD: begin
            state_in = ST_PRED_GET;
         end
         ST_PRED_GET: begin
            prev_in      = pred_rd;
            item_ra      = pg_item_addr;
            flow_ra      = pg_flow_addr;
            item_addr_in = pg_item_addr;
            flow_addr_in = pg_flow_addr;
            state_in     = ST_EDGE_EVAL;
         end
         ST_EDGE_EVAL: begin
            if (!phase_ff) begin
               if (!walk_fwd && (walk_cap < b_ff)) begin
                  b_in = walk_cap;
               end
            end else if (walk_item) begin
               item_we       = 1'b1;
               item_wd.resid = item_rd.resid - b_ff;
            end else begin
               flow_we        = 1'b1;
               flow_wd.amount = walk_fwd ? (flow_rd.amount + b_ff)
                                         : (flow_rd.amount - b_ff);
            end
            node_in = prev_ff;
            if (prev_ff == '0) begin
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  node_in  = sink;
                  state_in = ST_PRED_RD;
               end else begin
                  state_in = ST_BFS_INIT;
               end
            end else begin
               state_in = ST_PRED_RD;
            end
         end
         ST_SUM_RD: begin
            item_ra = IW'(nx_ff - NW'(1));
            if (nx_ff > n_node) begin
               state_in = ST_RESULT;
            end else if (vis_ff[nx_ff]) begin
               state_in = ST_SUM_EVAL;
            end else begin
               nx_in = nx_ff + NW'(1);
            end
         end
         ST_SUM_EVAL: begin
            total_in = total_ff - {{(TOTAL_W-VALUE_W){item_rd.value[VALUE_W-1]}},
                                   item_rd.value};
            nx_in    = nx_ff + NW'(1);
            state_in = ST_SUM_RD;
         end
         ST_RESULT: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_total_in = total_ff;
               out_ovf_in   = ovf_ff;
               n_in         = '0;
               total_in     = '0;
               final_in     = 1'b0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         n_ff         <= '0;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         final_ff     <= 1'b0;
         phase_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         final_ff     <= final_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ci_ff        <= ci_in;
      cj_ff        <= cj_in;
      mult_ff      <= mult_in;
      vis_ff       <= vis_in;
      neg_ff       <= neg_in;
      pos_ff       <= pos_in;
      head_ff      <= head_in;
      tail_ff      <= tail_in;
      cur_ff       <= cur_in;
      nx_ff        <= nx_in;
      node_ff      <= node_in;
      prev_ff      <= prev_in;
      b_ff         <= b_in;
      item_addr_ff <= item_addr_in;
      flow_addr_ff <= flow_addr_in;
      out_total_ff <= out_total_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_total  = out_total_ff;
   assign rsp_ovf    = out_ovf_ff;

endmodule

`default_nettype wire

// File: hw/rtl/dcmc_checker.sv
// ----------------------------------------------------------------------------
// dcmc_checker: port-level checks for the min-cut block
// Watches the result channel and req_tready over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dcmc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:25] == 7'b0)
      else $error("result padding not zero");

   a_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_tready, rsp_tvalid}) && (!rsp_tvalid || !$isunknown(rsp_tdata)))
      else $error("handshake or result unknown");

endmodule

bind divisor_closure_min_cut dcmc_checker u_dcmc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
